// ----- sv/fahq_pkg.sv -----
package fahq_pkg;

  localparam int unsigned DefCapacity = 1024;
  localparam int unsigned DefKeyBits  = 32;
  localparam int unsigned DefTagBits  = 16;

  localparam int unsigned StatusBits = 2;

  typedef enum logic [StatusBits-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

endpackage

// ----- sv/four_ary_min_heap_queue_top.sv -----
// Four-ary min-priority queue of (key, tag) entries held as an implicit heap in a single
// synchronous RAM of CAPACITY entries with a registered read port. One transaction is
// handled at a time: a push reads the parent and compares once per level that the entry
// climbs; a pop reads the root and the last entry, then per level descended reads each
// child in turn, then compares and writes back, all bound by the single RAM read port.
// Errors (pop on empty, push on full) go straight to the response and leave the contents
// unchanged.
module four_ary_min_heap_queue_top #(
  parameter int unsigned CAPACITY = fahq_pkg::DefCapacity,
  parameter int unsigned KEY_BITS = fahq_pkg::DefKeyBits,
  parameter int unsigned TAG_BITS = fahq_pkg::DefTagBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [KEY_BITS-1:0]                 key_i,
  input  logic [TAG_BITS-1:0]                 tag_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [KEY_BITS-1:0]                 out_key_o,
  output logic [TAG_BITS-1:0]                 out_tag_o,
  output logic [fahq_pkg::StatusBits-1:0]     status_o,
  output logic [$clog2(CAPACITY+1)-1:0]       count_o
);
  import fahq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KEY_BITS + TAG_BITS;
  localparam int unsigned FW = AW + 3;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UP_CHK = 4'd1;
  localparam logic [3:0] S_UP_CMP = 4'd2;
  localparam logic [3:0] S_POP_R0 = 4'd3;
  localparam logic [3:0] S_POP_RL = 4'd4;
  localparam logic [3:0] S_DN_LVL = 4'd5;
  localparam logic [3:0] S_DN_RD  = 4'd6;
  localparam logic [3:0] S_DN_DEC = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  logic [3:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       n_q, n_d;
  logic [AW-1:0]       i_q, i_d;
  logic [AW-1:0]       p_q, p_d;
  logic [EW-1:0]       held_q, held_d;
  logic [EW-1:0]       best_q, best_d;
  logic [AW-1:0]       best_idx_q, best_idx_d;
  logic                seen_q, seen_d;
  logic                pend_q, pend_d;
  logic [CW-1:0]       c_q, c_d;
  logic [CW-1:0]       pc_q, pc_d;
  logic [CW-1:0]       last_q, last_d;
  logic [KEY_BITS-1:0] okey_q, okey_d;
  logic [TAG_BITS-1:0] otag_q, otag_d;
  logic [StatusBits-1:0] ost_q, ost_d;

  logic [KEY_BITS-1:0] rd_key, held_key, best_key;
  logic [FW-1:0]       first_w, lastw;
  logic                issue;

  assign rd_key   = rd_data_q[EW-1:TAG_BITS];
  assign held_key = held_q[EW-1:TAG_BITS];
  assign best_key = best_q[EW-1:TAG_BITS];
  assign first_w  = {i_q, 2'b00} + FW'(1);
  assign lastw    = first_w + FW'(4);
  assign issue    = (c_q < last_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    n_d        = n_q;
    i_d        = i_q;
    p_d        = p_q;
    held_d     = held_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    seen_d     = seen_q;
    pend_d     = pend_q;
    c_d        = c_q;
    pc_d       = pc_q;
    last_d     = last_q;
    okey_d     = okey_q;
    otag_d     = otag_q;
    ost_d      = ost_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = i_q;
    wr_data    = held_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          okey_d = '0;
          otag_d = '0;
          ost_d  = ST_OK;
          if (cmd_i == CMD_PUSH) begin
            if (count_q >= CW'(CAPACITY)) begin
              ost_d   = ST_FULL;
              state_d = S_RESP;
            end else begin
              held_d  = {key_i, tag_i};
              i_d     = count_q[AW-1:0];
              count_d = count_q + CW'(1);
              state_d = S_UP_CHK;
            end
          end else begin
            if (count_q == '0) begin
              ost_d   = ST_EMPTY;
              state_d = S_RESP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              n_d     = count_q - CW'(1);
              count_d = count_q - CW'(1);
              state_d = S_POP_R0;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (i_q == '0) begin
          wr_en   = 1'b1;
          state_d = S_RESP;
        end else begin
          p_d     = (i_q - AW'(1)) >> 2;
          rd_en   = 1'b1;
          rd_addr = (i_q - AW'(1)) >> 2;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_key <= held_key) begin
          state_d = S_RESP;
        end else begin
          wr_data = rd_data_q;
          i_d     = p_q;
          state_d = S_UP_CHK;
        end
      end
      S_POP_R0: begin
        okey_d  = rd_key;
        otag_d  = rd_data_q[TAG_BITS-1:0];
        rd_en   = 1'b1;
        rd_addr = n_q[AW-1:0];
        state_d = S_POP_RL;
      end
      S_POP_RL: begin
        held_d = rd_data_q;
        i_d    = '0;
        if (n_q == '0) begin
          state_d = S_RESP;
        end else begin
          state_d = S_DN_LVL;
        end
      end
      S_DN_LVL: begin
        if (first_w >= FW'(n_q)) begin
          wr_en   = 1'b1;
          state_d = S_RESP;
        end else begin
          c_d     = CW'(first_w);
          last_d  = (lastw > FW'(n_q)) ? n_q : CW'(lastw);
          seen_d  = 1'b0;
          pend_d  = 1'b0;
          state_d = S_DN_RD;
        end
      end
      S_DN_RD: begin
        // Child reads are pipelined: one issued per cycle while the previous one is compared.
        if (pend_q && (!seen_q || rd_key < best_key)) begin
          best_d     = rd_data_q;
          best_idx_d = pc_q[AW-1:0];
          seen_d     = 1'b1;
        end
        rd_en   = issue;
        rd_addr = c_q[AW-1:0];
        pend_d  = issue;
        pc_d    = c_q;
        if (issue) begin
          c_d = c_q + CW'(1);
        end
        if (!issue && !pend_q) begin
          state_d = S_DN_DEC;
        end
      end
      S_DN_DEC: begin
        wr_en = 1'b1;
        if (best_key >= held_key) begin
          state_d = S_RESP;
        end else begin
          wr_data = best_q;
          i_d     = best_idx_q;
          state_d = S_DN_LVL;
        end
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      seen_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      seen_q  <= seen_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    i_q        <= i_d;
    p_q        <= p_d;
    held_q     <= held_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    c_q        <= c_d;
    pc_q       <= pc_d;
    last_q     <= last_d;
    okey_q     <= okey_d;
    otag_q     <= otag_d;
    ost_q      <= ost_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign out_key_o   = okey_q;
  assign out_tag_o   = otag_q;
  assign status_o    = ost_q;
  assign count_o     = count_q;

endmodule

// ----- verif/four_ary_min_heap_queue_top_tb.sv -----
module four_ary_min_heap_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fahq_pkg::*;

  localparam int unsigned Cap = DefCapacity;
  localparam int unsigned CntBits = $clog2(Cap + 1);
  localparam int unsigned RandItems = 550;
  localparam longint CycleLimit = 1500000;

  typedef struct packed {
    logic                  cmd;
    logic [DefKeyBits-1:0] key;
    logic [DefTagBits-1:0] tag;
  } heap_op_t;

  typedef struct packed {
    logic [DefKeyBits-1:0] key;
    logic [DefTagBits-1:0] tag;
    logic [StatusBits-1:0] status;
    logic [CntBits-1:0]    count;
  } heap_resp_t;

  typedef struct {
    heap_op_t   op;
    logic       has_resp;
    heap_resp_t resp;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = CMD_PUSH;
  logic [DefKeyBits-1:0] key_i = '0;
  logic [DefTagBits-1:0] tag_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [DefKeyBits-1:0] out_key_o;
  logic [DefTagBits-1:0] out_tag_o;
  logic [StatusBits-1:0] status_o;
  logic [CntBits-1:0] count_o;

  four_ary_min_heap_queue_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the heap.
  logic [DefKeyBits-1:0] heap_keys[Cap];
  logic [DefTagBits-1:0] heap_tags[Cap];
  int unsigned heap_size = 0;

  heap_resp_t pending_resps[$];
  int unsigned fail_count = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  longint cycle_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [DefKeyBits-1:0] k;
    logic [DefTagBits-1:0] t;
    k = heap_keys[a]; t = heap_tags[a];
    heap_keys[a] = heap_keys[b]; heap_tags[a] = heap_tags[b];
    heap_keys[b] = k; heap_tags[b] = t;
  endfunction

  function automatic heap_resp_t apply_heap_op(heap_op_t op);
    heap_resp_t r;
    int unsigned i, up, first, last, best;
    r = '0;
    r.status = ST_OK;
    if (op.cmd == CMD_PUSH) begin
      if (heap_size >= Cap) begin
        r.status = ST_FULL;
      end else begin
        heap_keys[heap_size] = op.key;
        heap_tags[heap_size] = op.tag;
        i = heap_size;
        heap_size++;
        while (i > 0) begin
          up = (i - 1) / 4;
          if (heap_keys[up] <= heap_keys[i]) break;
          swap_entries(up, i);
          i = up;
        end
      end
    end else begin
      if (heap_size == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key = heap_keys[0];
        r.tag = heap_tags[0];
        heap_size--;
        if (heap_size > 0) begin
          heap_keys[0] = heap_keys[heap_size];
          heap_tags[0] = heap_tags[heap_size];
          i = 0;
          forever begin
            first = i * 4 + 1;
            if (first >= heap_size) break;
            last = (first + 4 > heap_size) ? heap_size : first + 4;
            best = first;
            for (int unsigned c = first + 1; c < last; c++)
              if (heap_keys[c] < heap_keys[best]) best = c;
            if (heap_keys[best] >= heap_keys[i]) break;
            swap_entries(best, i);
            i = best;
          end
        end
      end
    end
    r.count = CntBits'(heap_size);
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [DefKeyBits-1:0] rand_key();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return DefKeyBits'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  // Valid stays high across a zero gap so it is assigned once per time step.
  task automatic send_op(heap_op_t op, logic has_resp, heap_resp_t resp);
    heap_resp_t pred;
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= op.cmd;
    key_i <= op.key;
    tag_i <= op.tag;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_heap_op(op);
    if (has_resp && pred != resp) report_mismatch("directed row", pred, resp);
    pending_resps.insert(pending_resps.size(), pred);
  endtask

  task automatic send_push(logic [DefKeyBits-1:0] k);
    heap_op_t op;
    op.cmd = CMD_PUSH; op.key = k; op.tag = DefTagBits'($urandom());
    send_op(op, 1'b0, '0);
  endtask

  task automatic send_pop();
    heap_op_t op;
    op.cmd = CMD_POP; op.key = $urandom(); op.tag = DefTagBits'($urandom());
    send_op(op, 1'b0, '0);
  endtask

  dir_row_t dir_rows[] = '{
    '{'{CMD_POP, 32'h0, 16'h0}, 1'b1, '{32'h0, 16'h0, ST_EMPTY, 11'd0}},
    '{'{CMD_POP, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{32'h0, 16'h0, ST_EMPTY, 11'd0}},
    '{'{CMD_PUSH, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{32'h0, 16'h0, ST_OK, 11'd1}},
    '{'{CMD_POP, 32'h0, 16'h0}, 1'b1, '{32'hFFFF_FFFF, 16'hFFFF, ST_OK, 11'd0}},
    '{'{CMD_PUSH, 32'h0, 16'h0}, 1'b1, '{32'h0, 16'h0, ST_OK, 11'd1}},
    '{'{CMD_POP, 32'h0, 16'h0}, 1'b1, '{32'h0, 16'h0, ST_OK, 11'd0}},
    // Equal keys with distinct tags check tie handling in both sifts.
    '{'{CMD_PUSH, 32'd5, 16'd1}, 1'b0, '0},
    '{'{CMD_PUSH, 32'd5, 16'd2}, 1'b0, '0},
    '{'{CMD_PUSH, 32'd5, 16'd3}, 1'b0, '0},
    '{'{CMD_PUSH, 32'd3, 16'd4}, 1'b0, '0},
    '{'{CMD_PUSH, 32'd5, 16'd5}, 1'b0, '0},
    '{'{CMD_PUSH, 32'd9, 16'd6}, 1'b0, '0},
    '{'{CMD_PUSH, 32'd1, 16'hAAAA}, 1'b0, '0},
    '{'{CMD_POP, 32'h0, 16'h0}, 1'b0, '0},
    '{'{CMD_POP, 32'h0, 16'h0}, 1'b0, '0},
    '{'{CMD_POP, 32'h0, 16'h0}, 1'b0, '0},
    '{'{CMD_POP, 32'h0, 16'h0}, 1'b0, '0},
    '{'{CMD_POP, 32'h0, 16'h0}, 1'b0, '0},
    '{'{CMD_POP, 32'h0, 16'h0}, 1'b0, '0},
    '{'{CMD_POP, 32'h0, 16'h0}, 1'b0, '0},
    '{'{CMD_POP, 32'h0, 16'h0}, 1'b1, '{32'h0, 16'h0, ST_EMPTY, 11'd0}}
  };

  initial begin
    int unsigned n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_op(dir_rows[i].op, dir_rows[i].has_resp, dir_rows[i].resp);
    // Fill to capacity with narrow keys so ties are common, then hit the full case.
    while (heap_size < Cap) send_push(DefKeyBits'($urandom_range(63)));
    send_push('1);
    send_push('0);
    // The random part starts from a full heap, so sifts run over the deepest levels.
    n = 0;
    while (n < RandItems) begin
      if ($urandom_range(99) < 45 && heap_size < Cap) send_push(rand_key());
      else send_pop();
      n++;
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls plus one long hold-off so the block backs up.
  initial begin
    int unsigned held;
    wait (rst_ni);
    forever begin
      if (!hold_off && cycle_count > 3000 && cycle_count < 3010) begin
        hold_off = 1'b1;
        out_ready_i <= 1'b0;
        held = 0;
        while (held < 400) begin
          @(posedge clk_i);
          held++;
        end
      end
      out_ready_i <= ($urandom_range(3) != 0) || (gap_len() == 0);
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    heap_resp_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_resps.size() == 0) begin
        report_mismatch("unexpected transaction", out_key_o, 0);
      end else begin
        want = pending_resps.pop_front();
        if (out_key_o !== want.key) report_mismatch("out_key", out_key_o, want.key);
        if (out_tag_o !== want.tag) report_mismatch("out_tag", out_tag_o, want.tag);
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (count_o !== want.count) report_mismatch("count", count_o, want.count);
      end
    end
  end

  initial begin
    wait (stim_done && pending_resps.size() == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
